// ----- hw/rtl/tlrqs_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlrqs_pkg: shared types and constants of the three level ready queue
// scheduler.
// Holds the operation, status and level codes, the slot word layout and the
// command group that the controller sends to the datapath.
// ----------------------------------------------------------------------------
package tlrqs_pkg;

   // Default number of thread slots in the table.
   localparam int THREAD_SLOTS_DEFAULT = 16;

   // Field widths.
   localparam int MODE_W     = 2;
   localparam int THREAD_W   = 8;
   localparam int PRIO_W     = 8;
   localparam int BURST_W    = 20;
   localparam int STATUS_W   = 2;
   localparam int LEVEL_W    = 2;
   localparam int CSR_IDX_W  = 8;
   localparam int CSR_DATA_W = 8;

   // Threshold reset values.
   localparam logic [PRIO_W-1:0] TOP_THRESH_RESET = 8'd100;
   localparam logic [PRIO_W-1:0] MID_THRESH_RESET = 8'd50;

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_TOP_THRESH = 8'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MID_THRESH = 8'd1;

   // Operation codes.
   localparam logic [MODE_W-1:0] MODE_INSERT = 2'd0;
   localparam logic [MODE_W-1:0] MODE_PICK   = 2'd1;
   localparam logic [MODE_W-1:0] MODE_REPRIO = 2'd2;

   // Status codes.
   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_EMPTY     = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

   // Level codes.
   localparam logic [LEVEL_W-1:0] LEVEL_NONE  = 2'd0;
   localparam logic [LEVEL_W-1:0] LEVEL_ONE   = 2'd1;
   localparam logic [LEVEL_W-1:0] LEVEL_TWO   = 2'd2;
   localparam logic [LEVEL_W-1:0] LEVEL_THREE = 2'd3;

   // One slot of the thread table memory.
   typedef struct packed {
      logic [LEVEL_W-1:0]  level;
      logic [THREAD_W-1:0] thread;
      logic [PRIO_W-1:0]   prio;
      logic [BURST_W-1:0]  burst;
   } slot_word_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;   // latch the request and clear the scan candidates
      logic read;      // read the slot at the scan index
      logic eval;      // compare the slot read last cycle
      logic commit;    // apply the operation and load the result
   } tlrqs_cmd_type;

endpackage : tlrqs_pkg
`default_nettype wire

// ----- hw/rtl/tlrqs_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlrqs_ctrl: sequencer of the ready queue scheduler.
// Accepts a command, walks the slot table, a read then a compare per slot,
// for pick and reprioritize, then commits and strobes the result.
// ----------------------------------------------------------------------------
module tlrqs_ctrl
   import tlrqs_pkg::*;
#(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(THREAD_SLOTS)
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire logic [MODE_W-1:0] req_mode,
   output logic                   busy,
   output logic                   rsp_valid,
   output tlrqs_cmd_type          cmd,
   output logic [IDX_W-1:0]       scan_idx
);

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(THREAD_SLOTS - 1);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_EVAL   = 4'b0100,
      ST_COMMIT = 4'b1000
   } state_type;

   state_type        state_ff, state_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             rsp_valid_ff, rsp_valid_in;

   // Next state, scan index and commands.
   always_comb begin
      state_in = state_ff;
      idx_in   = idx_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               idx_in      = '0;
               if (req_mode == MODE_PICK || req_mode == MODE_REPRIO) begin
                  state_in = ST_READ;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_READ: begin
            cmd.read = 1'b1;
            state_in = ST_EVAL;
         end
         ST_EVAL: begin
            cmd.eval = 1'b1;
            if (idx_ff == LAST_IDX) begin
               state_in = ST_COMMIT;
            end else begin
               idx_in   = idx_ff + 1'b1;
               state_in = ST_READ;
            end
         end
         ST_COMMIT: begin
            cmd.commit = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // The result strobe follows the commit cycle.
   assign rsp_valid_in = (state_ff == ST_COMMIT);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         idx_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign scan_idx  = idx_ff;

   // A scanning command goes straight into the table walk.
   a_scan_start: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_mode == MODE_PICK || req_mode == MODE_REPRIO))
      |=> state_ff == ST_READ)
      else $error("scan command did not start the table walk");

   // The commit lasts one cycle and is followed by exactly one strobe.
   a_commit_strobe: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_COMMIT |=> rsp_valid && state_ff == ST_IDLE)
      else $error("commit not followed by a result strobe");

   // A strobe is only ever produced by a commit.
   a_strobe_src: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_COMMIT))
      else $error("result strobe without a commit");

   // Strobes never come back to back.
   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("two result strobes in a row");

endmodule : tlrqs_ctrl
`default_nettype wire

// ----- hw/rtl/tlrqs_datapath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// tlrqs_datapath: slot table and selection logic of the scheduler.
// Holds the thresholds, the slot memory, valid bits and the arrival order
// matrix, tracks the best candidate per level during a scan and applies the
// operation on commit.
// ----------------------------------------------------------------------------
module tlrqs_datapath
   import tlrqs_pkg::*;
#(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEFAULT,
   localparam int IDX_W = $clog2(THREAD_SLOTS)
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire tlrqs_cmd_type         cmd,
   input  wire logic [IDX_W-1:0]      scan_idx,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [THREAD_W-1:0]   req_thread_id,
   input  wire logic [PRIO_W-1:0]     req_thread_priority,
   input  wire logic [BURST_W-1:0]    req_remaining_burst,
   input  wire logic                  csr_valid,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [THREAD_W-1:0]        rsp_picked_id,
   output logic [LEVEL_W-1:0]         rsp_picked_level
);

   // Thresholds.
   logic [PRIO_W-1:0] top_thresh_ff, mid_thresh_ff;

   // Latched request.
   logic [MODE_W-1:0]   mode_ff;
   logic [THREAD_W-1:0] tid_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [BURST_W-1:0]  burst_ff;

   // Slot table.
   slot_word_type              mem [THREAD_SLOTS];
   slot_word_type              rd_data_ff;
   logic [THREAD_SLOTS-1:0]    valid_ff;
   logic [THREAD_SLOTS-1:0]    older_ff [THREAD_SLOTS];

   // Per level scan candidates, entry 0 is level one.
   logic          cand_found_ff [3];
   logic [IDX_W-1:0] cand_idx_ff [3];
   slot_word_type cand_word_ff  [3];

   // Reprioritize lookup result.
   logic          match_found_ff;
   logic [IDX_W-1:0] match_idx_ff;
   slot_word_type match_word_ff;

   // Result payload.
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [THREAD_W-1:0] pid_ff, pid_in;
   logic [LEVEL_W-1:0]  plev_ff, plev_in;

   // Commit side effects.
   logic          mem_we;
   logic [IDX_W-1:0] mem_waddr;
   slot_word_type mem_wdata;
   logic          set_valid, clr_valid;
   logic [IDX_W-1:0] valid_idx;
   logic          young_en;
   logic [IDX_W-1:0] young_idx;

   // Scan evaluation signals.
   logic [1:0]    sel;
   logic          lvl_ok;
   slot_word_type best_word;
   logic [IDX_W-1:0] best_idx;
   logic          best_found;
   logic          older_bit;
   logic          better;
   logic          take;
   logic          hit;

   // Insert helpers.
   logic          free_found;
   logic [IDX_W-1:0] free_idx;
   logic [LEVEL_W-1:0] ins_level;

   // Pick choice.
   logic [1:0]    pick_sel;
   logic          pick_found;
   slot_word_type new_word;
   logic          promote;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         top_thresh_ff <= TOP_THRESH_RESET;
         mid_thresh_ff <= MID_THRESH_RESET;
      end else if (csr_valid) begin
         if (csr_index == CSR_TOP_THRESH) begin
            top_thresh_ff <= csr_wdata;
         end
         if (csr_index == CSR_MID_THRESH) begin
            mid_thresh_ff <= csr_wdata;
         end
      end
   end

   // Request latch.
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         mode_ff  <= req_mode;
         tid_ff   <= req_thread_id;
         prio_ff  <= req_thread_priority;
         burst_ff <= req_remaining_burst;
      end
   end

   // Candidate of the level of the slot that was just read.
   always_comb begin
      sel        = rd_data_ff.level - 2'd1;
      lvl_ok     = (rd_data_ff.level != LEVEL_NONE);
      best_word  = cand_word_ff[sel];
      best_idx   = cand_idx_ff[sel];
      best_found = cand_found_ff[sel] && lvl_ok;
      older_bit  = older_ff[scan_idx][best_idx];
      case (rd_data_ff.level)
         LEVEL_ONE: begin
            better = (rd_data_ff.burst < best_word.burst) ||
                     (rd_data_ff.burst == best_word.burst && older_bit);
         end
         LEVEL_TWO: begin
            better = (rd_data_ff.prio > best_word.prio) ||
                     (rd_data_ff.prio == best_word.prio && older_bit);
         end
         default: begin
            better = older_bit;
         end
      endcase
      take = cmd.eval && mode_ff == MODE_PICK && valid_ff[scan_idx] && lvl_ok &&
             (!best_found || better);
      hit  = cmd.eval && mode_ff == MODE_REPRIO && valid_ff[scan_idx] &&
             !match_found_ff && rd_data_ff.thread == tid_ff;
   end

   // Scan candidate registers.
   always_ff @(posedge clock) begin
      if (reset || cmd.capture) begin
         for (int l = 0; l < 3; l++) begin
            cand_found_ff[l] <= 1'b0;
         end
         match_found_ff <= 1'b0;
      end else begin
         if (take) begin
            cand_found_ff[sel] <= 1'b1;
         end
         if (hit) begin
            match_found_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cand_idx_ff[sel]  <= scan_idx;
         cand_word_ff[sel] <= rd_data_ff;
      end
      if (hit) begin
         match_idx_ff  <= scan_idx;
         match_word_ff <= rd_data_ff;
      end
   end

   // Lowest free slot.
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = THREAD_SLOTS - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Level from priority against the two thresholds.
   always_comb begin
      if (prio_ff >= top_thresh_ff) begin
         ins_level = LEVEL_ONE;
      end else if (prio_ff >= mid_thresh_ff) begin
         ins_level = LEVEL_TWO;
      end else begin
         ins_level = LEVEL_THREE;
      end
   end

   // First non-empty level wins the pick.
   always_comb begin
      pick_found = 1'b1;
      if (cand_found_ff[0]) begin
         pick_sel = 2'd0;
      end else if (cand_found_ff[1]) begin
         pick_sel = 2'd1;
      end else begin
         pick_sel   = 2'd2;
         pick_found = cand_found_ff[2];
      end
   end

   // Updated word of a reprioritized thread.
   always_comb begin
      new_word      = match_word_ff;
      new_word.prio = prio_ff;
      promote       = 1'b0;
      if (match_word_ff.level == LEVEL_TWO && prio_ff >= top_thresh_ff) begin
         new_word.level = LEVEL_ONE;
         promote        = 1'b1;
      end else if (match_word_ff.level == LEVEL_THREE && prio_ff >= mid_thresh_ff) begin
         new_word.level = LEVEL_TWO;
         promote        = 1'b1;
      end
   end

   // Commit: table updates and result.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = free_idx;
      mem_wdata = '{level: ins_level, thread: tid_ff, prio: prio_ff, burst: burst_ff};
      set_valid = 1'b0;
      clr_valid = 1'b0;
      valid_idx = free_idx;
      young_en  = 1'b0;
      young_idx = free_idx;
      status_in = STATUS_OK;
      pid_in    = '0;
      plev_in   = LEVEL_NONE;
      case (mode_ff)
         MODE_INSERT: begin
            if (free_found) begin
               mem_we    = cmd.commit;
               set_valid = cmd.commit;
               young_en  = cmd.commit;
               plev_in   = ins_level;
            end else begin
               status_in = STATUS_FULL;
            end
         end
         MODE_PICK: begin
            valid_idx = cand_idx_ff[pick_sel];
            if (pick_found) begin
               clr_valid = cmd.commit;
               pid_in    = cand_word_ff[pick_sel].thread;
               plev_in   = cand_word_ff[pick_sel].level;
            end else begin
               status_in = STATUS_EMPTY;
            end
         end
         MODE_REPRIO: begin
            mem_waddr = match_idx_ff;
            mem_wdata = new_word;
            young_idx = match_idx_ff;
            if (match_found_ff) begin
               mem_we   = cmd.commit;
               young_en = cmd.commit && promote;
               plev_in  = new_word.level;
            end else begin
               status_in = STATUS_NOT_FOUND;
            end
         end
         default: begin
            status_in = STATUS_OK;
         end
      endcase
   end

   // Slot memory with registered read.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      if (cmd.read) begin
         rd_data_ff <= mem[scan_idx];
      end
   end

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (set_valid) begin
         valid_ff[valid_idx] <= 1'b1;
      end else if (clr_valid) begin
         valid_ff[valid_idx] <= 1'b0;
      end
   end

   // Arrival order: bit j of row i means slot i arrived before slot j.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            older_ff[i] <= '0;
         end
      end else if (young_en) begin
         for (int i = 0; i < THREAD_SLOTS; i++) begin
            if (IDX_W'(i) == young_idx) begin
               older_ff[i] <= '0;
            end else if (valid_ff[i]) begin
               older_ff[i][young_idx] <= 1'b1;
            end
         end
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         status_ff <= status_in;
         pid_ff    <= pid_in;
         plev_ff   <= plev_in;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_picked_id    = pid_ff;
   assign rsp_picked_level = plev_ff;

endmodule : tlrqs_datapath
`default_nettype wire

// ----- hw/rtl/three_level_ready_queue_scheduler.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// three_level_ready_queue_scheduler: three level ready queue of threads.
// Inserts threads by priority level, picks the next thread to run and
// reprioritizes threads, promoting them past a threshold, over a table of thread slots.
//
//   Channel   Ports                                   Handshake
//   request   req_mode/thread_id/thread_priority/     start & !busy
//             req_remaining_burst
//   response  rsp_status/picked_id/picked_level       rsp_valid, one cycle
//   config    csr_index, csr_wdata                    csr_valid & csr_ready
//
// Insert and the unused mode go from accept straight to the commit state.
// Pick and reprioritize first walk the slot memory, one slot per read
// state and compare state pair; no new request is taken while busy.
// The result beat comes in the cycle after the commit; busy is already low
// then. The receiver cannot stall. csr_ready is always high.
// Synchronous active high reset empties the table and restores thresholds.
// ----------------------------------------------------------------------------
module three_level_ready_queue_scheduler
   import tlrqs_pkg::*;
#(
   parameter int THREAD_SLOTS = THREAD_SLOTS_DEFAULT
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   output logic                       busy,
   input  wire logic [MODE_W-1:0]     req_mode,
   input  wire logic [THREAD_W-1:0]   req_thread_id,
   input  wire logic [PRIO_W-1:0]     req_thread_priority,
   input  wire logic [BURST_W-1:0]    req_remaining_burst,
   output logic                       rsp_valid,
   output logic [STATUS_W-1:0]        rsp_status,
   output logic [THREAD_W-1:0]        rsp_picked_id,
   output logic [LEVEL_W-1:0]         rsp_picked_level,
   input  wire logic                  csr_valid,
   output logic                       csr_ready,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int IDX_W = $clog2(THREAD_SLOTS);

   tlrqs_cmd_type    cmd;
   logic [IDX_W-1:0] scan_idx;

   // Register writes are always taken.
   assign csr_ready = 1'b1;

   // Sequencer.
   tlrqs_ctrl #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .req_mode  (req_mode),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .scan_idx  (scan_idx)
   );

   // Slot table and selection.
   tlrqs_datapath #(
      .THREAD_SLOTS (THREAD_SLOTS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .scan_idx            (scan_idx),
      .req_mode            (req_mode),
      .req_thread_id       (req_thread_id),
      .req_thread_priority (req_thread_priority),
      .req_remaining_burst (req_remaining_burst),
      .csr_valid           (csr_valid),
      .csr_index           (csr_index),
      .csr_wdata           (csr_wdata),
      .rsp_status          (rsp_status),
      .rsp_picked_id       (rsp_picked_id),
      .rsp_picked_level    (rsp_picked_level)
   );

endmodule : three_level_ready_queue_scheduler
`default_nettype wire
